[sv/poisson_binomial_tail_product_unit_defines.svh]
// ----------------------------------------------------------------------------
// Poisson-binomial tail product unit: assertion macros
// Shared concurrent-assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef POISSON_BINOMIAL_TAIL_PRODUCT_UNIT_DEFINES_SVH
`define POISSON_BINOMIAL_TAIL_PRODUCT_UNIT_DEFINES_SVH

// Same-cycle implication
`define PBTP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PBTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pbtp_pkg.sv]
// ----------------------------------------------------------------------------
// pbtp_pkg
// Word types, controller/datapath interface structs and fixed-point helpers.
// ----------------------------------------------------------------------------
package pbtp_pkg;

  // Fixed point: FRAC_BITS fraction bits, ONE means 1.0
  localparam int FRAC_BITS = 16;
  localparam int PW        = FRAC_BITS + 1;
  localparam int NEED_W    = 6;
  localparam int SATW      = PW + 2;

  localparam logic [PW-1:0] PROB_ONE  = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] PROB_HALF = PW'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [PW-1:0]     agent_prob;
    logic              assigned;
    logic [NEED_W-1:0] need;
    logic              last_agent;
    logic              last_task;
  } in_t;

  typedef struct packed {
    logic [PW-1:0] task_prob;
    logic [PW-1:0] mission_prob;
    logic          mission_done;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic upd_step;
    logic sum_init;
    logic sum_step;
    logic mul;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic do_upd;
    logic last_agent;
    logic upd_last;
    logic sum_empty;
    logic sum_last;
    logic busy;
    logic out_free;
  } sts_t;

  // Clamp a non-negative value to ONE
  function automatic logic [PW-1:0] sat_one(input logic [SATW-1:0] v);
    logic [PW-1:0] r;
    if (v > SATW'(PROB_ONE)) begin
      r = PROB_ONE;
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

endpackage

[sv/pbtp_ctrl.sv]
// ----------------------------------------------------------------------------
// pbtp_ctrl
// Sequencer: per word, runs the update sweep if assigned and not full, then on
// a task's last agent the tail-sum sweep if any, the product multiply, result.
// ----------------------------------------------------------------------------
module pbtp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  pbtp_pkg::sts_t sts,
  output pbtp_pkg::cmd_t cmd,
  output logic          in_ready
);
  import pbtp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_UPD,
    S_UDRN,
    S_SUM,
    S_SDRN,
    S_MUL,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.do_upd) begin
          state_nxt = S_UPD;
        end else if (sts.last_agent) begin
          cmd.sum_init = 1'b1;
          state_nxt    = sts.sum_empty ? S_MUL : S_SUM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_UPD: begin
        cmd.upd_step = 1'b1;
        if (sts.upd_last) begin
          state_nxt = S_UDRN;
        end
      end
      S_UDRN: begin
        if (!sts.busy) begin
          if (sts.last_agent) begin
            cmd.sum_init = 1'b1;
            state_nxt    = sts.sum_empty ? S_MUL : S_SUM;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) begin
          state_nxt = S_SDRN;
        end
      end
      S_SDRN: begin
        if (!sts.busy) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

[sv/pbtp_dpath.sv]
// ----------------------------------------------------------------------------
// pbtp_dpath
// Distribution memory with a fill count, three-stage update pipeline
// (read, multiply pair, round and write back), tail accumulator, product
// multiplier and output register.
// ----------------------------------------------------------------------------
module pbtp_dpath #(
  parameter int MAX_AGENTS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pbtp_pkg::cmd_t  cmd,
  input  pbtp_pkg::in_t   in_data,
  input  logic           out_ready,
  output pbtp_pkg::sts_t  sts,
  output logic           out_valid,
  output pbtp_pkg::out_t  out_data
);
  import pbtp_pkg::*;

  localparam int DEPTH = MAX_AGENTS + 1;
  localparam int CW    = $clog2(DEPTH);
  localparam int NW    = ((CW > NEED_W) ? CW : NEED_W) + 1;
  localparam int PRODW = 2 * PW;
  localparam int ACCW  = PRODW + 1;

  // Distribution store; entries above the fill count read as zero
  logic [PW-1:0] mem [DEPTH];

  // Item registers
  logic [PW-1:0]     p_r, q_r;
  logic [NEED_W-1:0] need_r;
  logic              assigned_r, last_agent_r, last_task_r;

  // Control counters
  logic [CW-1:0] cnt_r, k_r;

  // Read stage
  logic [PW-1:0] rd_data_r;
  logic          s1_vld_r, s1_upd_r, s1_zero_r, s1_one_r;
  logic [CW-1:0] s1_addr_r;

  // Multiply stage
  logic [PW-1:0]    prev_r;
  logic [PRODW-1:0] prod_a_r, prod_b_r;
  logic             s2_vld_r;
  logic [CW-1:0]    s2_addr_r;

  // Tail sum and mission product
  logic [PW-1:0]    sum_r, run_r;
  logic [PRODW-1:0] prod_m_r;

  // Output register
  logic out_valid_r;
  out_t out_data_r;

  logic [PW-1:0]   p_sat, old_k, prev_use, wr_val, run_new;
  logic [ACCW-1:0] upd_acc, mul_acc;
  logic [PW:0]     sum_add;
  logic            issue;

  assign p_sat    = (in_data.agent_prob > PROB_ONE) ? PROB_ONE : in_data.agent_prob;
  assign old_k    = s1_zero_r ? '0 : (s1_one_r ? PROB_ONE : rd_data_r);
  assign prev_use = (s1_addr_r == '0) ? '0 : prev_r;
  assign issue    = cmd.upd_step | cmd.sum_step;

  // Round half up, shift, clamp
  assign upd_acc = ACCW'(prod_a_r) + ACCW'(prod_b_r) + ACCW'(PROB_HALF);
  assign wr_val  = sat_one(SATW'(upd_acc >> FRAC_BITS));
  assign mul_acc = ACCW'(prod_m_r) + ACCW'(PROB_HALF);
  assign run_new = sat_one(SATW'(mul_acc >> FRAC_BITS));
  assign sum_add = (PW + 1)'(sum_r) + (PW + 1)'(old_k);

  // Status
  assign sts.do_upd     = assigned_r && (cnt_r != CW'(MAX_AGENTS));
  assign sts.last_agent = last_agent_r;
  assign sts.upd_last   = ((CW + 1)'(k_r) == ((CW + 1)'(cnt_r) + (CW + 1)'(1)));
  assign sts.sum_empty  = (NW'(need_r) > NW'(cnt_r));
  assign sts.sum_last   = (k_r == cnt_r);
  assign sts.busy       = s1_vld_r | s2_vld_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Memory: read every cycle at the sweep index, write back from stage three
  always_ff @(posedge clk) begin
    rd_data_r <= mem[k_r];
    if (s2_vld_r) begin
      mem[s2_addr_r] <= wr_val;
    end
  end

  // Control state: counters, stage valids, product, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      k_r         <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      run_r       <= PROB_ONE;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r && s1_upd_r;

      // Advance the sweep index
      if (cmd.load) begin
        k_r <= '0;
      end else if (cmd.sum_init) begin
        k_r <= CW'(need_r);
      end else if (issue) begin
        k_r <= k_r + CW'(1);
      end

      // Grow the fill count at the end of an update sweep, drop it per task
      if (cmd.upd_step && sts.upd_last) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.emit) begin
        cnt_r <= '0;
      end

      if (cmd.emit) begin
        run_r       <= last_task_r ? PROB_ONE : run_new;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r          <= p_sat;
      q_r          <= PROB_ONE - p_sat;
      need_r       <= in_data.need;
      assigned_r   <= in_data.assigned;
      last_agent_r <= in_data.last_agent;
      last_task_r  <= in_data.last_task;
    end

    // Read stage flags: beyond fill count reads zero, empty store ONE at entry 0
    s1_upd_r  <= cmd.upd_step;
    s1_zero_r <= cmd.upd_step && (k_r > cnt_r);
    s1_one_r  <= (cnt_r == '0) && (k_r == '0);
    s1_addr_r <= k_r;

    // Multiply pair for the update
    if (s1_vld_r && s1_upd_r) begin
      prod_a_r  <= PRODW'(old_k) * PRODW'(q_r);
      prod_b_r  <= PRODW'(prev_use) * PRODW'(p_r);
      prev_r    <= old_k;
      s2_addr_r <= s1_addr_r;
    end

    // Tail accumulate with clamp
    if (cmd.sum_init) begin
      sum_r <= '0;
    end else if (s1_vld_r && !s1_upd_r) begin
      sum_r <= sat_one(SATW'(sum_add));
    end

    if (cmd.mul) begin
      prod_m_r <= PRODW'(run_r) * PRODW'(sum_r);
    end

    if (cmd.emit) begin
      out_data_r.task_prob    <= sum_r;
      out_data_r.mission_prob <= run_new;
      out_data_r.mission_done <= last_task_r;
    end
  end

endmodule

[sv/poisson_binomial_tail_product_unit.sv]
// ----------------------------------------------------------------------------
// poisson_binomial_tail_product_unit
// Task success probability as a Poisson-binomial tail, and mission product.
//
//   channel  ports                            word
//   input    in_valid / in_ready / in_data    one agent of the current task
//   result   out_valid / out_ready / out_data one word per last agent
//
// An agent word, when assigned and the store is not full, runs the update
// sweep over entries 0..count (count includes this agent) through the
// distribution memory. A last-agent word adds the tail sweep over entries
// need..count, then the product multiply and output load.
// Reset clears the fill count; the memory itself needs no clearing pass.
// A result still held in the output register does not stall agent words;
// the next last-agent word waits at output load, with input blocked, until
// that result is taken.
// ----------------------------------------------------------------------------
`include "poisson_binomial_tail_product_unit_defines.svh"

module poisson_binomial_tail_product_unit #(
  parameter int MAX_AGENTS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pbtp_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pbtp_pkg::out_t  out_data
);
  import pbtp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  pbtp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // Datapath
  pbtp_dpath #(
    .MAX_AGENTS (MAX_AGENTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Checks
  `PBTP_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid, "emit did not raise out_valid")
  `PBTP_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready held after accept")
  `PBTP_ASSERT_IMPL(a_one_sweep, cmd.upd_step, !cmd.sum_step, "update and sum sweeps overlap")
  `PBTP_ASSERT_IMPL(a_mul_drained, cmd.mul, !sts.busy, "product taken before tail sum drained")

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poisson-binomial tail product unit testbench
// Streams agent words (directed corner cases, then random tasks and
// missions with noise words) through the valid/ready input channel. Each
// accepted word runs through a local success-count distribution predictor.
// Results are checked in order, field by field, against the predicted queue.
// ----------------------------------------------------------------------------
module testbench;
  import pbtp_pkg::*;

  localparam int MAX_AGENTS   = 32;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_WORDS = 1400;

  typedef struct {
    in_t         word;
    int unsigned gap;
    bit          drain;
  } agent_word_t;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data  = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  agent_word_t pending_words[$];
  out_t        tail_results_q[$];

  // Predictor state
  logic [PW-1:0] succ_dist [0:MAX_AGENTS];
  int            succ_count;
  logic [PW-1:0] mission_acc;

  int unsigned errors          = 0;
  int unsigned words_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned missions_closed = 0;
  int unsigned agents_dropped  = 0;
  int unsigned cycle_count     = 0;

  // Sender idle pattern
  int unsigned calm_left = 0;
  bit          calm_mode = 1'b0;

  poisson_binomial_tail_product_unit #(
    .MAX_AGENTS(MAX_AGENTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Clamp to 1.0
  function automatic logic [PW-1:0] clamp_unit(input logic [63:0] v);
    return (v > 64'(PROB_ONE)) ? PROB_ONE : v[PW-1:0];
  endfunction

  // Round half up, drop fraction bits, clamp
  function automatic logic [PW-1:0] fx_round(input logic [63:0] acc);
    return clamp_unit((acc + 64'(PROB_HALF)) >> FRAC_BITS);
  endfunction

  task automatic clear_dist();
    int k;
    for (k = 0; k <= MAX_AGENTS; k++) begin
      succ_dist[k] = '0;
    end
    succ_dist[0] = PROB_ONE;
    succ_count   = 0;
  endtask

  // Apply one agent word; a last-agent word yields the tail and product
  task automatic predict_tail_product(input in_t w, output bit produced, output out_t res);
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] tail;
    int          k;
    p        = 64'(clamp_unit(64'(w.agent_prob)));
    q        = 64'(PROB_ONE) - p;
    produced = 1'b0;
    res      = '0;
    if (w.assigned) begin
      if (succ_count >= MAX_AGENTS) begin
        agents_dropped++;
      end else begin
        succ_count++;
        for (k = succ_count; k > 0; k--) begin
          succ_dist[k] = fx_round(64'(succ_dist[k]) * q + 64'(succ_dist[k-1]) * p);
        end
        succ_dist[0] = fx_round(64'(succ_dist[0]) * q);
      end
    end
    if (w.last_agent) begin
      tail = '0;
      for (k = int'(w.need); k <= succ_count; k++) begin
        tail += 64'(succ_dist[k]);
      end
      res.task_prob    = clamp_unit(tail);
      mission_acc      = fx_round(64'(mission_acc) * 64'(res.task_prob));
      res.mission_prob = mission_acc;
      res.mission_done = w.last_task;
      produced         = 1'b1;
      clear_dist();
      if (w.last_task) begin
        mission_acc = PROB_ONE;
      end
    end
  endtask

  // Queue one word with its idle gap
  task automatic queue_word(input logic [PW-1:0] prob, input bit asg,
                            input logic [NEED_W-1:0] need, input bit la, input bit lt,
                            input bit dr);
    agent_word_t item;
    if (calm_left == 0) begin
      calm_mode = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(20, 60);
    end
    calm_left--;
    item.word.agent_prob = prob;
    item.word.assigned   = asg;
    item.word.need       = need;
    item.word.last_agent = la;
    item.word.last_task  = lt;
    item.gap             = calm_mode ? 0 : $urandom_range(0, 15);
    item.drain           = dr;
    pending_words.insert(pending_words.size(), item);
  endtask

  function automatic logic [PW-1:0] draw_prob();
    logic [PW-1:0] r;
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = PROB_ONE;
      2: r = PW'($urandom_range(int'(PROB_ONE) + 1, (1 << PW) - 1));
      3, 4: r = PW'($urandom_range(58000, int'(PROB_ONE)));
      default: r = PW'($urandom_range(0, int'(PROB_ONE)));
    endcase
    return r;
  endfunction

  function automatic logic [NEED_W-1:0] draw_need(input int n);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      return NEED_W'($urandom_range(0, n));
    end else if (sel < 85) begin
      return NEED_W'($urandom_range(0, MAX_AGENTS));
    end
    return NEED_W'($urandom);
  endfunction

  function automatic int unsigned draw_stall();
    return (cycle_count[9:8] == 2'd0) ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void check_field(input string name, input logic [PW-1:0] want,
                                      input logic [PW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Drive input words: hold each until accepted, wait out its gap first
  int unsigned gap_left   = 0;
  bit          gap_loaded = 1'b0;
  always @(posedge clk) begin : drive_words
    logic busy;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      gap_loaded = 1'b0;
    end else begin
      busy = in_valid && !in_ready;
      if (!busy && pending_words.size() > 0) begin
        if (!gap_loaded) begin
          gap_left   = pending_words[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending_words[0].drain ||
                     (!in_valid && tail_results_q.size() == 0)) begin
          in_data    <= pending_words[0].word;
          pending_words.pop_front();
          gap_loaded = 1'b0;
          busy       = 1'b1;
        end
      end
      in_valid <= busy;
    end
  end

  // Accept result words with random stalls
  int unsigned stall_left = 0;
  always @(posedge clk) begin : accept_results
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        stall_left = draw_stall();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check results against the oldest prediction, then predict new words
  always @(posedge clk) begin : check_words
    bit   produced;
    out_t res;
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (tail_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        end else begin
          want = tail_results_q.pop_front();
          check_field("task_prob", want.task_prob, out_data.task_prob);
          check_field("mission_prob", want.mission_prob, out_data.mission_prob);
          check_field("mission_done", PW'(want.mission_done), PW'(out_data.mission_done));
          results_checked++;
          if (want.mission_done) begin
            missions_closed++;
          end
        end
      end
      if (in_valid && in_ready) begin
        words_accepted++;
        predict_tail_product(in_data, produced, res);
        if (produced) begin
          tail_results_q.insert(tail_results_q.size(), res);
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, tail_results_q.size());
      $display("FAIL poisson_binomial_tail_product_unit");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_count;
    int unsigned tasks_left;
    int          n;
    int          a;
    bit          last;
    bit          dr;
    clear_dist();
    mission_acc = PROB_ONE;

    // Directed: probability extremes, saturation above one
    queue_word('0, 1'b1, 6'h3f, 1'b0, 1'b1, 1'b0);
    queue_word(PROB_ONE, 1'b1, '0, 1'b0, 1'b0, 1'b0);
    queue_word(PW'('1), 1'b1, 6'd2, 1'b1, 1'b0, 1'b0);
    // Unassigned words, last_task ignored off the last agent
    queue_word(PW'('1), 1'b0, 6'h3f, 1'b0, 1'b1, 1'b0);
    queue_word(PW'(12345), 1'b0, 6'd0, 1'b1, 1'b0, 1'b0);
    // Need zero: whole distribution
    queue_word(PW'(32768), 1'b1, 6'd0, 1'b1, 1'b0, 1'b0);
    // Need above count: zero tail, product drops to zero
    queue_word(PW'(32768), 1'b1, 6'd9, 1'b0, 1'b0, 1'b0);
    queue_word(PW'(16384), 1'b1, 6'h3f, 1'b1, 1'b0, 1'b0);
    queue_word(PROB_ONE, 1'b1, 6'd5, 1'b1, 1'b1, 1'b0);
    // Fresh mission with small and near-one probabilities
    queue_word(PW'(1), 1'b1, 6'd0, 1'b0, 1'b0, 1'b0);
    queue_word(PW'(65535), 1'b1, 6'd0, 1'b0, 1'b0, 1'b0);
    queue_word(PROB_ONE, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0);
    queue_word(PW'(40000), 1'b1, 6'd1, 1'b1, 1'b0, 1'b0);
    queue_word(PW'(60000), 1'b1, 6'd32, 1'b1, 1'b0, 1'b0);
    queue_word(PW'(50000), 1'b1, 6'd1, 1'b0, 1'b0, 1'b0);
    queue_word(PW'(50000), 1'b1, 6'd2, 1'b1, 1'b1, 1'b0);
    queue_word(PW'(65000), 1'b1, 6'd1, 1'b1, 1'b1, 1'b0);

    // One full task past the agent limit, sent after a full drain
    random_count = 0;
    for (a = 0; a < MAX_AGENTS + 2; a++) begin
      last = (a == MAX_AGENTS + 1);
      queue_word(PW'($urandom_range(62000, int'(PROB_ONE))), 1'b1,
                 last ? NEED_W'(MAX_AGENTS) : NEED_W'($urandom), last, last, a == 0);
    end
    random_count += MAX_AGENTS + 2;

    // Random tasks grouped into missions, with noise words
    tasks_left = $urandom_range(1, 6);
    while (random_count < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 85) begin
        a = $urandom_range(0, 99);
        if (a < 88) begin
          n = $urandom_range(1, 8);
        end else if (a < 97) begin
          n = $urandom_range(9, 31);
        end else begin
          n = $urandom_range(MAX_AGENTS, MAX_AGENTS + 4);
        end
        dr = ($urandom_range(0, 49) == 0);
        for (a = 0; a < n; a++) begin
          last = (a == n - 1);
          queue_word(draw_prob(), $urandom_range(0, 99) < 85,
                     last ? draw_need(n) : NEED_W'($urandom), last,
                     last ? (tasks_left == 1) : 1'($urandom), dr && a == 0);
        end
        random_count += n;
        tasks_left--;
        if (tasks_left == 0) begin
          tasks_left = $urandom_range(1, 6);
        end
      end else begin
        n = $urandom_range(1, 4);
        for (a = 0; a < n; a++) begin
          queue_word(PW'($urandom), 1'($urandom), NEED_W'($urandom), 1'($urandom),
                     1'($urandom), 1'b0);
        end
        random_count += n;
      end
    end

    // Release reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all words to go in and all results to come out
    @(negedge clk);
    while (pending_words.size() > 0 || in_valid || tail_results_q.size() > 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d agent words, checked %0d task results over %0d closed missions,",
             words_accepted, results_checked, missions_closed);
    $display("with %0d agents dropped past the agent limit, %0d mismatches.",
             agents_dropped, errors);
    if (errors == 0) begin
      $display("PASS poisson_binomial_tail_product_unit");
    end else begin
      $display("FAIL poisson_binomial_tail_product_unit");
    end
    $finish;
  end

endmodule

[poisson_binomial_tail_product_unit.f]
+incdir+sv
sv/pbtp_pkg.sv
sv/pbtp_ctrl.sv
sv/pbtp_dpath.sv
sv/poisson_binomial_tail_product_unit.sv
dv/testbench.sv
